// File: rtl/pogq_pkg.sv
// Shared types and constants of the upstream grant queue.
// Used by the controller, the datapath, the top level and the checker.
package pogq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int MAX_RESULTS  = 33;
    localparam int MAX_RELEASE  = MAX_RESULTS - 1;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int REL_W        = $clog2(MAX_RELEASE + 1);

    localparam int TAG_W        = 16;
    localparam int LEN_W        = 14;
    localparam int BITS_W       = 24;
    localparam int OVH_W        = 16;
    localparam int CHAN_W       = 6;
    localparam int BURST_W      = 25;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_OVERHEAD = 2'd1;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_GRANT   = 1'b1;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_HEADER = 2'd2
    } pogq_kind_t;

    typedef struct packed {
        logic capture;
        logic enqueue;
        logic mem_read;
        logic pop;
        logic load_header;
    } pogq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_grant;
        logic fits;
    } pogq_stat_t;

endpackage

// File: rtl/pogq_ctrl.sv
// Controller state machine of the upstream grant queue.
// Depends on pogq_pkg; drives commands into pogq_datapath.
module pogq_ctrl import pogq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pogq_stat_t stat,
    output pogq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ENQ   = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CHECK = 4'b1000
    } pogq_state_t;

    pogq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ENQ;
                end
            end
            ST_ENQ: begin
                if (stat.is_grant) begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_CHECK;
                end else if (stat.out_free) begin
                    cmd.enqueue = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.out_free) begin
                    if (stat.fits) begin
                        cmd.pop    = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.load_header = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pogq_datapath.sv
// Datapath of the upstream grant queue: descriptor memory, pointers,
// occupancy, grant accounting and the output register. Depends on pogq_pkg.
module pogq_datapath import pogq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pogq_cmd_t             cmd,
    output pogq_stat_t            stat,
    input  logic                  s_opcode,
    input  logic [TAG_W-1:0]      s_frame_tag,
    input  logic [LEN_W-1:0]      s_frame_bits,
    input  logic [BITS_W-1:0]     s_grant_bits,
    input  logic [CHAN_W-1:0]     s_grant_channel,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic                  m_accepted,
    output logic [TAG_W-1:0]      m_out_tag,
    output logic [LEN_W-1:0]      m_out_frame_bits,
    output logic [BITS_W-1:0]     m_report_bits,
    output logic [CHAN_W-1:0]     m_out_channel,
    output logic [BURST_W-1:0]    m_burst_bits,
    output logic                  m_last
);

    logic [TAG_W+LEN_W-1:0] mem [QUEUE_DEPTH];
    logic [TAG_W+LEN_W-1:0] rd_data_reg;

    logic [BITS_W-1:0]  limit_reg;
    logic [OVH_W-1:0]   overhead_reg;

    logic               opcode_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [BITS_W-1:0]  grant_reg;
    logic [CHAN_W-1:0]  chan_reg;

    logic [PTR_W-1:0]   head_reg, tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [BITS_W-1:0]  occ_reg;
    logic [BITS_W-1:0]  sent_reg;
    logic [REL_W-1:0]   rel_reg;

    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic               out_acc_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [BITS_W-1:0]  out_rep_reg;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic [BURST_W-1:0] out_burst_reg;
    logic               out_last_reg;

    logic [1:0]         out_kind_next;
    logic               out_acc_next;
    logic [TAG_W-1:0]   out_tag_next;
    logic [LEN_W-1:0]   out_len_next;
    logic [BITS_W-1:0]  out_rep_next;
    logic [CHAN_W-1:0]  out_chan_next;
    logic [BURST_W-1:0] out_burst_next;
    logic               out_last_next;

    logic [TAG_W-1:0]   rd_tag;
    logic [LEN_W-1:0]   rd_len;
    logic               enq_ok;
    logic [BITS_W:0]    sent_sum;
    logic [BITS_W-1:0]  occ_after_pop;
    logic               load_any;

    assign rd_tag = rd_data_reg[TAG_W+LEN_W-1:LEN_W];
    assign rd_len = rd_data_reg[LEN_W-1:0];

    assign enq_ok = ({1'b0, occ_reg} + {{(BITS_W-LEN_W+1){1'b0}}, len_reg}
                     <= {1'b0, limit_reg})
                    && (count_reg < CNT_W'(QUEUE_DEPTH));

    assign sent_sum = {1'b0, sent_reg} + {{(BITS_W-LEN_W+1){1'b0}}, rd_len};

    assign occ_after_pop = (occ_reg >= {{(BITS_W-LEN_W){1'b0}}, rd_len})
                           ? occ_reg - {{(BITS_W-LEN_W){1'b0}}, rd_len}
                           : '0;

    assign stat.out_free = !out_valid_reg || m_ready;
    assign stat.is_grant = (opcode_reg == OP_GRANT);
    assign stat.fits     = (grant_reg != '0) && (count_reg != '0)
                           && (rel_reg < REL_W'(MAX_RELEASE))
                           && (sent_sum <= {1'b0, grant_reg});

    assign load_any = cmd.enqueue || cmd.pop || cmd.load_header;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= '0;
            overhead_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_QUEUE_LIMIT:    limit_reg    <= cfg_data[BITS_W-1:0];
                REG_BURST_OVERHEAD: overhead_reg <= cfg_data[OVH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg <= s_opcode;
            tag_reg    <= s_frame_tag;
            len_reg    <= s_frame_bits;
            grant_reg  <= s_grant_bits;
            chan_reg   <= s_grant_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enqueue && enq_ok) begin
            mem[tail_reg] <= {tag_reg, len_reg};
        end
        if (cmd.mem_read) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            occ_reg   <= '0;
            sent_reg  <= '0;
            rel_reg   <= '0;
        end else begin
            if (cmd.capture) begin
                sent_reg <= '0;
                rel_reg  <= '0;
            end
            if (cmd.enqueue && enq_ok) begin
                tail_reg  <= (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
                count_reg <= count_reg + CNT_W'(1);
                occ_reg   <= occ_reg + {{(BITS_W-LEN_W){1'b0}}, len_reg};
            end
            if (cmd.pop) begin
                head_reg  <= (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
                count_reg <= count_reg - CNT_W'(1);
                occ_reg   <= occ_after_pop;
                sent_reg  <= sent_sum[BITS_W-1:0];
                rel_reg   <= rel_reg + REL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_any) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_kind_next  = KIND_STATUS;
        out_acc_next   = 1'b0;
        out_tag_next   = '0;
        out_len_next   = '0;
        out_rep_next   = '0;
        out_chan_next  = '0;
        out_burst_next = '0;
        out_last_next  = 1'b1;
        if (cmd.enqueue) begin
            out_acc_next = enq_ok;
        end else if (cmd.pop) begin
            out_kind_next = KIND_FRAME;
            out_tag_next  = rd_tag;
            out_len_next  = rd_len;
            out_last_next = 1'b0;
        end else if (cmd.load_header) begin
            out_kind_next  = KIND_HEADER;
            out_rep_next   = occ_reg;
            out_chan_next  = chan_reg;
            out_burst_next = {{(BURST_W-OVH_W){1'b0}}, overhead_reg}
                             + {{(BURST_W-BITS_W){1'b0}}, sent_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (load_any) begin
            out_kind_reg  <= out_kind_next;
            out_acc_reg   <= out_acc_next;
            out_tag_reg   <= out_tag_next;
            out_len_reg   <= out_len_next;
            out_rep_reg   <= out_rep_next;
            out_chan_reg  <= out_chan_next;
            out_burst_reg <= out_burst_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_kind_reg;
    assign m_accepted       = out_acc_reg;
    assign m_out_tag        = out_tag_reg;
    assign m_out_frame_bits = out_len_reg;
    assign m_report_bits    = out_rep_reg;
    assign m_out_channel    = out_chan_reg;
    assign m_burst_bits     = out_burst_reg;
    assign m_last           = out_last_reg;

endmodule

// File: rtl/pon_onu_grant_queue_top.sv
// Top level of the upstream grant queue: controller plus datapath.
// Depends on pogq_pkg, pogq_ctrl and pogq_datapath.
//
// Upstream frame queue of an optical network unit. An enqueue word stores a
// frame descriptor (tag, bit length) in a 32-entry FIFO if it fits the bit
// limit and a free entry, and returns one status word. A grant word releases
// up to 32 frames from the head in order while they fit a nonzero grant, one
// word per frame, then a burst header word with the remaining occupied bits,
// the channel and the burst length. The block takes one input word at a time;
// a grant reads each head descriptor through a registered memory read and
// checks it before it releases the frame. A waiting output word stalls the
// block until it is taken. Configuration writes are accepted in every cycle.
module pon_onu_grant_queue_top import pogq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [TAG_W-1:0]      s_frame_tag,
    input  logic [LEN_W-1:0]      s_frame_bits,
    input  logic [BITS_W-1:0]     s_grant_bits,
    input  logic [CHAN_W-1:0]     s_grant_channel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic                  m_accepted,
    output logic [TAG_W-1:0]      m_out_tag,
    output logic [LEN_W-1:0]      m_out_frame_bits,
    output logic [BITS_W-1:0]     m_report_bits,
    output logic [CHAN_W-1:0]     m_out_channel,
    output logic [BURST_W-1:0]    m_burst_bits,
    output logic                  m_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pogq_cmd_t  cmd;
    pogq_stat_t stat;

    assign cfg_ready = 1'b1;

    pogq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pogq_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_frame_tag      (s_frame_tag),
        .s_frame_bits     (s_frame_bits),
        .s_grant_bits     (s_grant_bits),
        .s_grant_channel  (s_grant_channel),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_accepted       (m_accepted),
        .m_out_tag        (m_out_tag),
        .m_out_frame_bits (m_out_frame_bits),
        .m_report_bits    (m_report_bits),
        .m_out_channel    (m_out_channel),
        .m_burst_bits     (m_burst_bits),
        .m_last           (m_last)
    );

endmodule

// File: rtl/pogq_checker.sv
// Port-level checks of the upstream grant queue, bound to the top level.
// Depends on pogq_pkg and pon_onu_grant_queue_top.
module pogq_checker import pogq_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_result_kind,
    input logic                  m_accepted,
    input logic [TAG_W-1:0]      m_out_tag,
    input logic [LEN_W-1:0]      m_out_frame_bits,
    input logic [BITS_W-1:0]     m_report_bits,
    input logic [CHAN_W-1:0]     m_out_channel,
    input logic [BURST_W-1:0]    m_burst_bits,
    input logic                  m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_accepted) && $stable(m_out_tag)
            && $stable(m_out_frame_bits) && $stable(m_report_bits)
            && $stable(m_out_channel) && $stable(m_burst_bits) && $stable(m_last))
        else $error("output word changed while stalled");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_result_kind != KIND_FRAME)))
        else $error("last flag does not match word kind");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word in progress");

    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_result_kind == KIND_STATUS)
        else $error("accepted flag outside status word");

endmodule

bind pon_onu_grant_queue_top pogq_checker u_pogq_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench of the upstream grant queue (pon_onu_grant_queue_top).
// A scoreboard predicts every status, released frame and burst header word.
// Depends on pogq_pkg and the RTL of the block.
module tb_top;
    import pogq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES   = 12;
    localparam int ITEMS_PER_PHASE = 6;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        pogq_kind_t          kind;
        logic                accepted;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    flen;
        logic [BITS_W-1:0]   report;
        logic [CHAN_W-1:0]   chan;
        logic [BURST_W-1:0]  burst;
        logic                last;
    } queue_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_opcode = OP_ENQUEUE;
    logic [TAG_W-1:0]      s_frame_tag = '0;
    logic [LEN_W-1:0]      s_frame_bits = '0;
    logic [BITS_W-1:0]     s_grant_bits = '0;
    logic [CHAN_W-1:0]     s_grant_channel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [1:0]            m_result_kind;
    logic                  m_accepted;
    logic [TAG_W-1:0]      m_out_tag;
    logic [LEN_W-1:0]      m_out_frame_bits;
    logic [BITS_W-1:0]     m_report_bits;
    logic [CHAN_W-1:0]     m_out_channel;
    logic [BURST_W-1:0]    m_burst_bits;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pon_onu_grant_queue_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_frame_tag     (s_frame_tag),
        .s_frame_bits    (s_frame_bits),
        .s_grant_bits    (s_grant_bits),
        .s_grant_channel (s_grant_channel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_accepted      (m_accepted),
        .m_out_tag       (m_out_tag),
        .m_out_frame_bits(m_out_frame_bits),
        .m_report_bits   (m_report_bits),
        .m_out_channel   (m_out_channel),
        .m_burst_bits    (m_burst_bits),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    queue_word_t         expected_words[$];
    queue_word_t         head_word;
    logic [TAG_W-1:0]    q_tag [QUEUE_DEPTH];
    logic [LEN_W-1:0]    q_len [QUEUE_DEPTH];
    logic [PTR_W-1:0]    q_head = '0;
    logic [PTR_W-1:0]    q_tail = '0;
    int                  q_count = 0;
    logic [BITS_W-1:0]   q_occupied = '0;
    logic [BITS_W-1:0]   cur_limit = '0;
    logic [OVH_W-1:0]    cur_overhead = '0;

    int                  err_count = 0;
    int                  cycle_count = 0;
    int                  sink_hold = 0;
    bit                  src_stall_en = 1'b1;
    bit                  sink_stall_en = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LEN_W-1:0] rand_frame_bits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return LEN_W'($urandom_range(1, 600));
        if (r < 95) return LEN_W'($urandom_range(1, 16383));
        return (r < 97) ? '1 : LEN_W'(1);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic predict_word(logic op, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] flen,
                                logic [BITS_W-1:0] grant, logic [CHAN_W-1:0] chan);
        queue_word_t     w;
        logic [BITS_W:0] sent;
        int              n;
        bit              fits;
        w = '0;
        if (op == OP_ENQUEUE) begin
            fits = (({1'b0, q_occupied} + (BITS_W+1)'(flen)) <= {1'b0, cur_limit})
                   && (q_count < QUEUE_DEPTH);
            if (fits) begin
                q_tag[q_tail] = tag;
                q_len[q_tail] = flen;
                q_tail = (q_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail + PTR_W'(1);
                q_count++;
                q_occupied = q_occupied + BITS_W'(flen);
            end
            w.kind = KIND_STATUS;
            w.accepted = fits;
            w.last = 1'b1;
            expected_words.push_back(w);
        end else begin
            sent = '0;
            n = 0;
            if (grant != '0) begin
                while (q_count > 0 && n < MAX_RELEASE) begin
                    if (sent + (BITS_W+1)'(q_len[q_head]) > {1'b0, grant}) break;
                    sent = sent + (BITS_W+1)'(q_len[q_head]);
                    q_occupied = (q_occupied >= BITS_W'(q_len[q_head]))
                                 ? q_occupied - BITS_W'(q_len[q_head]) : '0;
                    w = '0;
                    w.kind = KIND_FRAME;
                    w.tag = q_tag[q_head];
                    w.flen = q_len[q_head];
                    expected_words.push_back(w);
                    n++;
                    q_head = (q_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + PTR_W'(1);
                    q_count--;
                end
            end
            w = '0;
            w.kind = KIND_HEADER;
            w.report = q_occupied;
            w.chan = chan;
            w.burst = BURST_W'(cur_overhead) + sent;
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    // Leaves s_valid high after acceptance; a drain or a source gap lowers it.
    task automatic send_word(logic op, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] flen,
                             logic [BITS_W-1:0] grant, logic [CHAN_W-1:0] chan);
        int gap;
        gap = src_stall_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_frame_tag     <= tag;
        s_frame_bits    <= flen;
        s_grant_bits    <= grant;
        s_grant_channel <= chan;
        do @(posedge aclk); while (!s_ready);
        predict_word(op, tag, flen, grant, chan);
    endtask

    task automatic send_enqueue(logic [TAG_W-1:0] tag, logic [LEN_W-1:0] flen);
        send_word(OP_ENQUEUE, tag, flen, BITS_W'($urandom()), CHAN_W'($urandom()));
    endtask

    task automatic send_grant(logic [BITS_W-1:0] grant, logic [CHAN_W-1:0] chan);
        send_word(OP_GRANT, TAG_W'($urandom()), LEN_W'($urandom()), grant, chan);
    endtask

    task automatic wait_queue_empty();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_QUEUE_LIMIT) cur_limit = data[BITS_W-1:0];
        else if (idx == REG_BURST_OVERHEAD) cur_overhead = data[OVH_W-1:0];
    endtask

    task automatic test_reset_state();
        send_grant('0, '0);
        send_enqueue(16'h1234, 14'd1);
        send_enqueue('1, '0);
        send_grant(24'd1, '1);
        send_grant('0, 6'h15);
    endtask

    task automatic test_field_extremes();
        wait_queue_empty();
        write_reg(REG_QUEUE_LIMIT, '1);
        write_reg(REG_BURST_OVERHEAD, '1);
        write_reg(REG_SPARE_A, '0);
        write_reg(REG_SPARE_B, '1);
        send_enqueue('1, '1);
        send_enqueue('0, 14'd1);
        send_enqueue(16'h5A5A, 14'h2AAA);
        send_enqueue(16'hA5A5, 14'h1555);
        send_grant(24'd16383, 6'h2A);
        send_grant('0, '1);
        send_grant(24'd1, 6'h15);
        send_grant('1, '0);
        wait_queue_empty();
        write_reg(REG_BURST_OVERHEAD, '0);
        write_reg(REG_QUEUE_LIMIT, 24'd16383);
        send_enqueue(16'h00FF, '1);
        send_enqueue(16'hFF00, 14'd1);
        send_grant(24'h800000, 6'h2A);
    endtask

    task automatic test_fifo_full();
        int i;
        wait_queue_empty();
        write_reg(REG_QUEUE_LIMIT, '1);
        write_reg(REG_BURST_OVERHEAD, 24'h00ABCD);
        for (i = 0; i <= QUEUE_DEPTH; i++)
            send_enqueue(TAG_W'($urandom()), LEN_W'($urandom_range(1, 500)));
        send_grant('1, CHAN_W'($urandom()));
        send_enqueue(TAG_W'($urandom()), rand_frame_bits());
        send_grant('1, CHAN_W'($urandom()));
    endtask

    task automatic test_limit_lowered();
        wait_queue_empty();
        write_reg(REG_QUEUE_LIMIT, '1);
        send_enqueue(16'h0101, 14'd2000);
        send_enqueue(16'h0202, 14'd2000);
        send_enqueue(16'h0303, 14'd2000);
        wait_queue_empty();
        write_reg(REG_QUEUE_LIMIT, 24'd1000);
        send_enqueue(16'h0404, 14'd1);
        send_grant('0, 6'd7);
        send_grant(24'd4000, 6'd8);
        send_enqueue(16'h0505, '0);
        send_grant('1, 6'd9);
        send_enqueue(16'h0606, 14'd1000);
        send_enqueue(16'h0707, 14'd1);
        send_grant('1, 6'd10);
    endtask

    task automatic run_burst(int frames);
        int                i;
        int                r;
        logic [BITS_W-1:0] grant;
        for (i = 0; i < frames; i++)
            send_enqueue(TAG_W'($urandom()), rand_frame_bits());
        r = $urandom_range(0, 99);
        if (r < 12) grant = '0;
        else if (r < 30) grant = '1;
        else grant = BITS_W'($urandom_range(1, int'(q_occupied) + 1));
        send_grant(grant, CHAN_W'($urandom()));
    endtask

    task automatic test_random_traffic();
        int phase;
        int count;
        int frames;
        bit paused;
        paused = 1'b0;
        for (phase = 0; phase < 5; phase++) begin
            wait_queue_empty();
            case (phase)
                0: begin
                    write_reg(REG_QUEUE_LIMIT, '1);
                    write_reg(REG_BURST_OVERHEAD, CFG_DATA_W'($urandom()));
                end
                1: begin
                    write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'($urandom_range(16383, 80000)));
                    write_reg(REG_BURST_OVERHEAD, 24'h00FFFF);
                end
                2: begin
                    write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'($urandom()));
                    write_reg(REG_BURST_OVERHEAD, '0);
                end
                3: begin
                    write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'($urandom_range(0, 5000)));
                    write_reg(REG_BURST_OVERHEAD, CFG_DATA_W'($urandom()));
                end
                default: begin
                    write_reg(REG_QUEUE_LIMIT, '1);
                    write_reg(REG_BURST_OVERHEAD, CFG_DATA_W'($urandom()));
                end
            endcase
            src_stall_en = (phase != 1);
            sink_stall_en = (phase != 1);
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    frames = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                         : $urandom_range(1, 8);
                    run_burst(frames);
                    count += frames + 1;
                end else begin
                    send_word(($urandom_range(0, 1) != 0) ? OP_GRANT : OP_ENQUEUE,
                              TAG_W'($urandom()), LEN_W'($urandom()),
                              BITS_W'($urandom()), CHAN_W'($urandom()));
                    count++;
                end
                if (phase == 3 && !paused) begin
                    wait_queue_empty();
                    paused = 1'b1;
                end
            end
        end
        src_stall_en = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || !sink_stall_en) begin
            m_ready <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            sink_hold <= pick_gap();
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                head_word = expected_words.pop_front();
                check_field("result_kind", 32'(m_result_kind), 32'(head_word.kind));
                check_field("accepted", 32'(m_accepted), 32'(head_word.accepted));
                check_field("out_tag", 32'(m_out_tag), 32'(head_word.tag));
                check_field("out_frame_bits", 32'(m_out_frame_bits), 32'(head_word.flen));
                check_field("report_bits", 32'(m_report_bits), 32'(head_word.report));
                check_field("out_channel", 32'(m_out_channel), 32'(head_word.chan));
                check_field("burst_bits", 32'(m_burst_bits), 32'(head_word.burst));
                check_field("last", 32'(m_last), 32'(head_word.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);
        test_reset_state();
        test_field_extremes();
        test_fifo_full();
        test_limit_lowered();
        test_random_traffic();
        wait_queue_empty();
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/pogq_pkg.sv
rtl/pogq_ctrl.sv
rtl/pogq_datapath.sv
rtl/pon_onu_grant_queue_top.sv
rtl/pogq_checker.sv
tb/sv/tb_top.sv
